// File: rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// TCP session tracker package
// Shared types, result codes and constants of the session tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam logic [31:0] INITIAL_SEQ       = 32'd1000;
   localparam logic [15:0] LISTEN_PORT_RESET = 16'd23;

   typedef enum logic [2:0] {
      ST_WRONG_PORT   = 3'd0,
      ST_CREATED      = 3'd1,
      ST_FULL         = 3'd2,
      ST_SYN_EXISTING = 3'd3,
      ST_ACKED        = 3'd4,
      ST_IGNORED      = 3'd5,
      ST_SENT         = 3'd6,
      ST_BAD_SLOT     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_ADD_SEQ = 2'd1,
      OP_SET_ACK = 2'd2,
      OP_CREATE  = 2'd3
   } op_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      logic take;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/tst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tst_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 5,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tst_ctrl.sv
// ----------------------------------------------------------------------------
// Session tracker controller
// Sequences accept and commit of one word at a time.
// ----------------------------------------------------------------------------
module tst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tst_pkg::dp_status_type stat,
   output tst_pkg::ctl_cmd_type   cmd
);

   tst_pkg::state_type state_ff;
   tst_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.take   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         tst_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = tst_pkg::S_UPDATE;
            end
         end
         tst_pkg::S_UPDATE: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = tst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/tst_datapath.sv
// ----------------------------------------------------------------------------
// Session tracker datapath
// Session table, lookup, sequence/acknowledge update and result register.
// ----------------------------------------------------------------------------
module tst_datapath #(
   parameter int SLOTS = 5,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tst_pkg::ctl_cmd_type   cmd,
   output tst_pkg::dp_status_type stat,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   action,
   input  logic [31:0]            peer_addr,
   input  logic [15:0]            peer_port,
   input  logic [15:0]            local_port,
   input  logic                   syn_flag,
   input  logic                   psh_flag,
   input  logic [31:0]            segment_seq,
   input  logic [15:0]            byte_count,
   input  logic [2:0]             send_slot,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [2:0]             rsp_slot,
   output logic [31:0]            rsp_seq,
   output logic [31:0]            rsp_ack
);

   localparam int CMP_W = (IDX_W > 3) ? IDX_W : 3;

   logic [15:0]          listen_port_ff;
   logic [SLOTS-1:0]     active_ff;
   logic [31:0]          addr_ff [SLOTS];
   logic [15:0]          port_ff [SLOTS];

   tst_pkg::status_type  status_ff;
   tst_pkg::op_type      op_ff;
   logic                 has_slot_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [31:0]          seg_seq_ff;
   logic [15:0]          count_ff;
   logic [31:0]          peer_addr_ff;
   logic [15:0]          peer_port_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [2:0]           rsp_slot_ff;
   logic [31:0]          rsp_seq_ff;
   logic [31:0]          rsp_ack_ff;

   logic                 match_hit;
   logic [IDX_W-1:0]     match_idx;
   logic                 free_hit;
   logic [IDX_W-1:0]     free_idx;
   logic                 sel_ok;
   tst_pkg::status_type  dec_status;
   tst_pkg::op_type      dec_op;
   logic                 dec_has;
   logic [IDX_W-1:0]     dec_idx;

   logic [63:0]          rd_data;
   logic [31:0]          cur_seq;
   logic [31:0]          cur_ack;
   logic [31:0]          new_seq;
   logic [31:0]          new_ack;
   logic                 wr_en;

   // table search: lowest matching and lowest free entry
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      free_hit  = 1'b0;
      free_idx  = '0;
      sel_ok    = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (active_ff[i] && addr_ff[i] == peer_addr && port_ff[i] == peer_port) begin
            match_hit = 1'b1;
            match_idx = IDX_W'(i);
         end
         if (!active_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (active_ff[i] && CMP_W'(send_slot) == CMP_W'(i)) begin
            sel_ok = 1'b1;
         end
      end
   end

   always_comb begin
      dec_status = tst_pkg::ST_IGNORED;
      dec_op     = tst_pkg::OP_NONE;
      dec_has    = 1'b0;
      dec_idx    = match_idx;
      priority if (action) begin
         if (sel_ok) begin
            dec_status = tst_pkg::ST_SENT;
            dec_op     = tst_pkg::OP_ADD_SEQ;
            dec_has    = 1'b1;
            dec_idx    = IDX_W'(send_slot);
         end else begin
            dec_status = tst_pkg::ST_BAD_SLOT;
         end
      end else if (local_port != listen_port_ff) begin
         dec_status = tst_pkg::ST_WRONG_PORT;
      end else if (syn_flag) begin
         if (match_hit) begin
            dec_status = tst_pkg::ST_SYN_EXISTING;
            dec_has    = 1'b1;
         end else if (free_hit) begin
            dec_status = tst_pkg::ST_CREATED;
            dec_op     = tst_pkg::OP_CREATE;
            dec_has    = 1'b1;
            dec_idx    = free_idx;
         end else begin
            dec_status = tst_pkg::ST_FULL;
         end
      end else if (psh_flag && match_hit) begin
         dec_status = tst_pkg::ST_ACKED;
         dec_op     = tst_pkg::OP_SET_ACK;
         dec_has    = 1'b1;
      end else begin
         dec_status = tst_pkg::ST_IGNORED;
         dec_has    = match_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         status_ff    <= dec_status;
         op_ff        <= dec_op;
         has_slot_ff  <= dec_has;
         idx_ff       <= dec_idx;
         seg_seq_ff   <= segment_seq;
         count_ff     <= byte_count;
         peer_addr_ff <= peer_addr;
         peer_port_ff <= peer_port;
      end
   end

   tst_ram #(
      .WIDTH (64),
      .DEPTH (SLOTS),
      .ADDR_W(IDX_W)
   ) u_seq_ack_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(idx_ff),
      .wr_data({new_seq, new_ack}),
      .rd_en  (cmd.take),
      .rd_addr(dec_idx),
      .rd_data(rd_data)
   );

   assign cur_seq = rd_data[63:32];
   assign cur_ack = rd_data[31:0];

   always_comb begin
      new_seq = cur_seq;
      new_ack = cur_ack;
      unique case (op_ff)
         tst_pkg::OP_NONE: begin
         end
         tst_pkg::OP_ADD_SEQ: begin
            new_seq = cur_seq + {16'd0, count_ff};
         end
         tst_pkg::OP_SET_ACK: begin
            new_ack = seg_seq_ff + {16'd0, count_ff};
         end
         tst_pkg::OP_CREATE: begin
            new_seq = tst_pkg::INITIAL_SEQ;
            new_ack = seg_seq_ff + 32'd1;
         end
         default: begin
         end
      endcase
   end

   assign wr_en = cmd.commit && (op_ff != tst_pkg::OP_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_port_ff <= tst_pkg::LISTEN_PORT_RESET;
         active_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            listen_port_ff <= csr_wr_data;
         end
         if (cmd.commit && op_ff == tst_pkg::OP_CREATE) begin
            active_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && op_ff == tst_pkg::OP_CREATE) begin
         addr_ff[idx_ff] <= peer_addr_ff;
         port_ff[idx_ff] <= peer_port_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= has_slot_ff ? 3'(idx_ff) : 3'd0;
         rsp_seq_ff    <= has_slot_ff ? new_seq : 32'd0;
         rsp_ack_ff    <= has_slot_ff ? new_ack : 32'd0;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_seq       = rsp_seq_ff;
   assign rsp_ack       = rsp_ack_ff;

endmodule

// File: rtl/tcp_session_tracker_top.sv
// ----------------------------------------------------------------------------
// TCP session tracker
// Connection table keyed by peer address and port; tracks send sequence
// and acknowledge number per session.
// ----------------------------------------------------------------------------
//  Port group   Direction  Carries
//  req_*        in         segment received or payload sent (one word)
//  rsp_*        out        status, slot, sequence and acknowledge (one word)
//  csr_*        in         listening port register write
//
//  Per word: the accept cycle searches the table and reads the slot's
//  sequence/acknowledge RAM, then the update state updates it and loads the
//  result register. One word is in work at a time.
//  Reset clears the session table's active bits and sets the port to 23.
//  A stalled result register holds the update cycle until rsp_tready.
// ----------------------------------------------------------------------------
module tcp_session_tracker_top #(
   parameter int SLOTS = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // peer_addr, peer_port, local_port, syn_flag, psh_flag, segment_seq,
   // byte_count, send_slot, zero pad
   input  logic [119:0] req_tdata,
   // action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot, seq_now, ack_now, zero pad
   output logic [71:0]  rsp_tdata,
   // status
   output logic [2:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   tst_pkg::ctl_cmd_type   cmd;
   tst_pkg::dp_status_type stat;
   logic [2:0]             rsp_slot;
   logic [31:0]            rsp_seq;
   logic [31:0]            rsp_ack;

   tst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   tst_datapath #(
      .SLOTS(SLOTS),
      .IDX_W(IDX_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .action     (req_tuser),
      .peer_addr  (req_tdata[31:0]),
      .peer_port  (req_tdata[47:32]),
      .local_port (req_tdata[63:48]),
      .syn_flag   (req_tdata[64]),
      .psh_flag   (req_tdata[65]),
      .segment_seq(req_tdata[97:66]),
      .byte_count (req_tdata[113:98]),
      .send_slot  (req_tdata[116:114]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_slot   (rsp_slot),
      .rsp_seq    (rsp_seq),
      .rsp_ack    (rsp_ack)
   );

   assign rsp_tdata = {5'd0, rsp_ack, rsp_seq, rsp_slot};

endmodule

// File: tb/tcp_session_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// TCP session tracker testbench
// Drives received segments and payload-sent words into the tracker, predicts
// each result from a private copy of the session table and checks every
// result word field by field. Directed words cover the corner cases, then
// random phases run under several listening ports with random idling on
// both sides, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_session_tracker_top_tb;

   localparam int SLOTS       = 5;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_LIMIT  = 5000;
   localparam int PHASES      = 6;
   localparam int PHASE_WORDS = 230;

   typedef struct packed {
      logic [2:0]  pad;
      logic [2:0]  send_slot;
      logic [15:0] byte_count;
      logic [31:0] segment_seq;
      logic        psh_flag;
      logic        syn_flag;
      logic [15:0] local_port;
      logic [15:0] peer_port;
      logic [31:0] peer_addr;
   } seg_word_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] ack_now;
      logic [31:0] seq_now;
      logic [2:0]  slot;
   } rsp_word_type;

   typedef struct packed {
      tst_pkg::status_type status;
      rsp_word_type        body;
   } session_result_type;

   class session_table_type;
      logic [15:0]        listen_port;
      bit                 active [SLOTS];
      logic [31:0]        peer_addr [SLOTS];
      logic [15:0]        peer_port [SLOTS];
      logic [31:0]        snd_seq [SLOTS];
      logic [31:0]        rcv_ack [SLOTS];
      int unsigned        used;
      session_result_type pending_results [$];
      int                 errors;
      int                 words_noted;
      int                 status_seen [8];

      function new();
         listen_port = tst_pkg::LISTEN_PORT_RESET;
         used        = 0;
         errors      = 0;
         words_noted = 0;
         foreach (active[k]) begin
            active[k] = 1'b0;
         end
         foreach (status_seen[k]) begin
            status_seen[k] = 0;
         end
      endfunction

      function void note_segment(bit act, seg_word_type w);
         session_result_type r;
         int                 hit;
         r   = '0;
         hit = -1;
         words_noted++;
         if (act) begin
            if (w.send_slot < SLOTS && active[w.send_slot]) begin
               snd_seq[w.send_slot] = snd_seq[w.send_slot] + 32'(w.byte_count);
               r.status = tst_pkg::ST_SENT;
               hit = w.send_slot;
            end else begin
               r.status = tst_pkg::ST_BAD_SLOT;
            end
         end else if (w.local_port != listen_port) begin
            r.status = tst_pkg::ST_WRONG_PORT;
         end else begin
            for (int k = 0; k < SLOTS; k++) begin
               if (hit < 0 && active[k] && peer_addr[k] == w.peer_addr &&
                   peer_port[k] == w.peer_port) begin
                  hit = k;
               end
            end
            if (w.syn_flag) begin
               if (hit >= 0) begin
                  r.status = tst_pkg::ST_SYN_EXISTING;
               end else if (used >= SLOTS) begin
                  r.status = tst_pkg::ST_FULL;
               end else begin
                  for (int k = 0; k < SLOTS; k++) begin
                     if (hit < 0 && !active[k]) begin
                        hit = k;
                     end
                  end
                  active[hit]    = 1'b1;
                  peer_addr[hit] = w.peer_addr;
                  peer_port[hit] = w.peer_port;
                  snd_seq[hit]   = tst_pkg::INITIAL_SEQ;
                  rcv_ack[hit]   = w.segment_seq + 32'd1;
                  used++;
                  r.status = tst_pkg::ST_CREATED;
               end
            end else if (hit >= 0 && w.psh_flag) begin
               rcv_ack[hit] = w.segment_seq + 32'(w.byte_count);
               r.status = tst_pkg::ST_ACKED;
            end else begin
               r.status = tst_pkg::ST_IGNORED;
            end
         end
         if (hit >= 0) begin
            r.body.slot    = 3'(hit);
            r.body.seq_now = snd_seq[hit];
            r.body.ack_now = rcv_ack[hit];
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [2:0] got_status, rsp_word_type got);
         session_result_type exp;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: status %0d slot %0d", got_status, got.slot);
            errors++;
            return;
         end
         exp = pending_results.pop_front();
         status_seen[exp.status]++;
         if (got_status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got_status);
            errors++;
         end
         if (got.slot !== exp.body.slot) begin
            $error("slot: expected %0d, got %0d", exp.body.slot, got.slot);
            errors++;
         end
         if (got.seq_now !== exp.body.seq_now) begin
            $error("seq_now: expected %0h, got %0h", exp.body.seq_now, got.seq_now);
            errors++;
         end
         if (got.ack_now !== exp.body.ack_now) begin
            $error("ack_now: expected %0h, got %0h", exp.body.ack_now, got.ack_now);
            errors++;
         end
      endfunction
   endclass

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata   = '0;
   logic         req_tuser   = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [71:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_wr_en   = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   session_table_type tracker = new();

   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;
   bit hold_req  = 1'b0;
   int idle_cycles = 0;

   logic [47:0] known_peers [6] = '{
      {32'h0000_0000, 16'h0000},
      {32'h0000_0000, 16'hFFFF},
      {32'hFFFF_FFFF, 16'h0000},
      {32'hFFFF_FFFF, 16'hFFFF},
      {32'h1234_5678, 16'd23},
      {32'h0000_0000, 16'h0001}
   };

   always #1 clock = ~clock;

   tcp_session_tracker_top #(
      .SLOTS(SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_result(rsp_tuser, rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            tracker.note_segment(req_tuser, req_tdata);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_wr_en) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tcp_session_tracker_top test failed");
            $finish;
         end
      end
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else if (stalls_on) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(bit act, seg_word_type w);
      req_tuser  <= act;
      req_tdata  <= w;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_segment(logic [47:0] peer, logic [15:0] lport, bit syn, bit psh,
                               logic [31:0] seq, logic [15:0] cnt);
      seg_word_type w;
      w = '0;
      {w.peer_addr, w.peer_port} = peer;
      w.local_port  = lport;
      w.syn_flag    = syn;
      w.psh_flag    = psh;
      w.segment_seq = seq;
      w.byte_count  = cnt;
      send_word(1'b0, w);
   endtask

   task automatic send_payload(logic [2:0] slot, logic [15:0] cnt);
      seg_word_type w;
      w = '0;
      w.send_slot  = slot;
      w.byte_count = cnt;
      send_word(1'b1, w);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_listen_port(logic [15:0] port);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= port;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.listen_port = port;
   endtask

   function automatic seg_word_type random_segment(output bit act);
      seg_word_type w;
      logic [127:0] bits;
      int           pick;
      bits = {$urandom, $urandom, $urandom, $urandom};
      w    = bits[119:0];
      w.pad = '0;
      act  = 1'b0;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
         w.byte_count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      if ($urandom_range(0, 7) == 0) begin
         w.segment_seq = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      end
      if (pick < 20) begin
         act = 1'b1;
         if ($urandom_range(0, 2) != 0) begin
            w.send_slot = 3'($urandom_range(0, SLOTS - 1));
         end
      end else if (pick < 30) begin
         w.local_port = tracker.listen_port + 16'($urandom_range(1, 65535));
      end else begin
         w.local_port = tracker.listen_port;
         if (pick < 85) begin
            {w.peer_addr, w.peer_port} = known_peers[$urandom_range(0, 5)];
         end
         w.syn_flag = ($urandom_range(0, 4) == 0);
         w.psh_flag = ($urandom_range(0, 9) < 6);
      end
      return w;
   endfunction

   initial begin
      logic [15:0]  phase_ports [PHASES];
      seg_word_type w;
      bit           act;
      int           fails;

      phase_ports = '{16'h0000, 16'hFFFF, 16'($urandom), 16'd80, 16'($urandom), 16'd23};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: sends, wrong port, stray segments
      send_payload(3'd0, 16'd5);
      send_payload(3'd7, 16'hFFFF);
      send_payload(3'd5, 16'd1);
      send_segment(known_peers[0], 16'd24, 1'b1, 1'b0, 32'd7, 16'd0);
      send_segment(known_peers[0], tst_pkg::LISTEN_PORT_RESET, 1'b0, 1'b1, 32'd7, 16'd9);
      send_segment(known_peers[0], tst_pkg::LISTEN_PORT_RESET, 1'b0, 1'b0, 32'd7, 16'd9);
      // open first session with acknowledge wrap, then revisit it
      send_segment(known_peers[0], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b0,
                   32'hFFFF_FFFF, 16'd0);
      send_segment(known_peers[0], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b1, 32'd3, 16'd3);
      send_segment(known_peers[0], tst_pkg::LISTEN_PORT_RESET, 1'b0, 1'b1,
                   32'hFFFF_FFFF, 16'hFFFF);
      send_segment(known_peers[0], tst_pkg::LISTEN_PORT_RESET, 1'b0, 1'b0, 32'd1, 16'd1);
      send_payload(3'd0, 16'hFFFF);
      send_payload(3'd0, 16'd0);
      send_payload(3'd1, 16'd10);
      // fill the table, then overflow it
      send_segment(known_peers[1], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b0, 32'd0, 16'd0);
      send_segment(known_peers[2], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b1,
                   32'h8000_0000, 16'hFFFF);
      send_segment(known_peers[3], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b0,
                   32'h7FFF_FFFF, 16'd1);
      send_segment(known_peers[4], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b0,
                   32'h1234_5678, 16'd2);
      send_segment(known_peers[5], tst_pkg::LISTEN_PORT_RESET, 1'b1, 1'b0, 32'd5, 16'd5);
      send_segment(known_peers[5], tst_pkg::LISTEN_PORT_RESET, 1'b0, 1'b1, 32'd5, 16'd5);
      send_payload(3'd4, 16'd1);
      send_segment(known_peers[3], tst_pkg::LISTEN_PORT_RESET, 1'b0, 1'b1, 32'd0, 16'd0);
      send_segment(known_peers[3], 16'hFFFF, 1'b0, 1'b1, 32'd9, 16'd9);
      // payload word with every unused field set
      w = '1;
      w.pad = '0;
      w.send_slot = 3'd3;
      send_word(1'b1, w);
      w.send_slot = 3'd6;
      send_word(1'b1, w);

      for (int p = 0; p < PHASES; p++) begin
         write_listen_port(phase_ports[p]);
         gaps_on   = (p != PHASES - 1);
         stalls_on = (p != PHASES - 1);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (p == 1 && i == 50) begin
               hold_req = 1'b1;
            end
            if (p == 2 && i == 100) begin
               drain_results();
            end
            w = random_segment(act);
            send_word(act, w);
         end
      end

      drain_results();
      repeat (20) @(posedge clock);

      $display("Covered %0d words over %0d listening-port settings; %0d of %0d slots in use.",
               tracker.words_noted, PHASES + 1, tracker.used, SLOTS);
      $display("By status: port %0d created %0d full %0d syn-existing %0d acked %0d",
               tracker.status_seen[tst_pkg::ST_WRONG_PORT],
               tracker.status_seen[tst_pkg::ST_CREATED],
               tracker.status_seen[tst_pkg::ST_FULL],
               tracker.status_seen[tst_pkg::ST_SYN_EXISTING],
               tracker.status_seen[tst_pkg::ST_ACKED]);
      $display("           ignored %0d sent %0d bad-slot %0d",
               tracker.status_seen[tst_pkg::ST_IGNORED],
               tracker.status_seen[tst_pkg::ST_SENT],
               tracker.status_seen[tst_pkg::ST_BAD_SLOT]);

      fails = tracker.errors + tracker.pending_results.size();
      if (fails == 0) begin
         $display("tcp_session_tracker_top test passed");
      end else begin
         $display("tcp_session_tracker_top test failed");
      end
      $finish;
   end

endmodule
